FILE: hw/rtl/ptla_pkg.sv
// ----------------------------------------------------------------------------
// ptla_pkg: shared types and constants of the peer table
// Request and status codes, register indexes, reset values and the records
// that pass between the sequencer, the table store and the top level.
// ----------------------------------------------------------------------------
package ptla_pkg;

	localparam int ADDR_W    = 48;
	localparam int TICK_W    = 32;
	localparam int QUERY_W   = 4;
	localparam int STATUS_W  = 3;
	localparam int PIDX_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int MAXP_W    = 5;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [MAXP_W-1:0]    MAX_PEERS_RST = MAXP_W'(16);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(1000);

	typedef enum logic [1:0] {
		REQ_PACKET = 2'd0,
		REQ_POLL   = 2'd1,
		REQ_QUERY  = 2'd2
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DELIVERED    = 3'd0,
		ST_HELLO        = 3'd1,
		ST_NOT_CLIENT   = 3'd2,
		ST_FULL         = 3'd3,
		ST_EXPIRED      = 3'd4,
		ST_NONE_EXPIRED = 3'd5,
		ST_VALID        = 3'd6,
		ST_INVALID      = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLIENT_MODE = 2'd0,
		CFG_MAX_PEERS   = 2'd1,
		CFG_TIMEOUT     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINAL
	} seq_state_t;

	typedef struct packed {
		logic                 client_mode;
		logic [MAXP_W-1:0]    max_peers;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [ADDR_W-1:0]  src_addr;
		logic               is_hello;
		logic [TICK_W-1:0]  tick;
		logic [QUERY_W-1:0] peer_query;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PIDX_W-1:0]   peer_index;
		logic                new_peer;
		logic                send_reply;
		logic [COUNT_W-1:0]  peer_count;
	} res_t;

	typedef struct packed {
		logic              addr_en;
		logic              ls_en;
		logic [ADDR_W-1:0] addr;
		logic [TICK_W-1:0] ls;
	} mem_wr_t;

endpackage

FILE: hw/rtl/ptla_if.sv
// ----------------------------------------------------------------------------
// ptla interfaces: request, result and register write channels
// Each channel moves one beat when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptla_req_if import ptla_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [ADDR_W-1:0]  src_addr;
	logic               is_hello;
	logic [TICK_W-1:0]  tick;
	logic [QUERY_W-1:0] peer_query;

	modport source (output valid, req_type, src_addr, is_hello, tick, peer_query,
		input ready);
	modport sink (input valid, req_type, src_addr, is_hello, tick, peer_query,
		output ready);
endinterface

interface ptla_rsp_if import ptla_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PIDX_W-1:0]   peer_index;
	logic                new_peer;
	logic                send_reply;
	logic [COUNT_W-1:0]  peer_count;

	modport source (output valid, status, peer_index, new_peer, send_reply, peer_count,
		input ready);
	modport sink (input valid, status, peer_index, new_peer, send_reply, peer_count,
		output ready);
endinterface

interface ptla_cfg_if import ptla_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ptla_store.sv
// ----------------------------------------------------------------------------
// ptla_store: peer address and last-seen memories
// One read and one write port per cycle, read data registered. A valid bit
// per entry makes a never-written last-seen entry read as zero (free).
// ----------------------------------------------------------------------------
module ptla_store import ptla_pkg::*; #(
	parameter int NUM_PEERS = 16,
	localparam int IW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_idx,
	output logic [ADDR_W-1:0]    rd_addr,
	output logic [TICK_W-1:0]    rd_ls,
	input  logic [IW-1:0]        wr_idx,
	input  mem_wr_t              wr
);
	logic [ADDR_W-1:0]    addr_mem [NUM_PEERS];
	logic [TICK_W-1:0]    ls_mem [NUM_PEERS];
	logic [NUM_PEERS-1:0] vld_q;
	logic [TICK_W-1:0]    ls_raw_q;
	logic                 rd_vld_q;

	// write and read the arrays
	always_ff @(posedge clk) begin
		if (wr.addr_en) addr_mem[wr_idx] <= wr.addr;
		if (wr.ls_en) ls_mem[wr_idx] <= wr.ls;
		if (rd_en) begin
			rd_addr  <= addr_mem[rd_idx];
			ls_raw_q <= ls_mem[rd_idx];
		end
	end

	// track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.ls_en) vld_q[wr_idx] <= 1'b1;
			if (rd_en) rd_vld_q <= vld_q[rd_idx];
		end
	end

	assign rd_ls = rd_vld_q ? ls_raw_q : '0;

endmodule

FILE: hw/rtl/ptla_seq.sv
// ----------------------------------------------------------------------------
// ptla_seq: request sequencer
// Scans the table one entry per cycle, then decides, writes back if the request
// changes the table and pushes one result into the output register.
// ----------------------------------------------------------------------------
module ptla_seq import ptla_pkg::*; #(
	parameter int NUM_PEERS = 16,
	localparam int IW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_item_t         item,
	input  logic              res_free,
	output logic              res_push,
	output res_t              res,
	output logic              rd_en,
	output logic [IW-1:0]     rd_idx,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [TICK_W-1:0] rd_ls,
	output logic [IW-1:0]     wr_idx,
	output mem_wr_t           wr
);
	localparam int CW = $clog2(NUM_PEERS + 1);

	seq_state_t state_q, state_d;
	req_item_t  item_q;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] iss_q, len_q, top_q, lim;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          hit_q, free_q;
	logic [IW-1:0] hidx_q, fidx_q;
	logic          is_pkt, issue, stop, accept;
	logic          stale, ls_zero;
	logic [TICK_W-1:0] expiry;

	assign is_pkt = (item_q.req_type == REQ_PACKET);
	assign accept = in_valid && in_ready;
	assign issue  = (state_q == S_SCAN) && (iss_q != len_q) && !(hit_q && is_pkt);
	assign stop   = !v_s1 && ((iss_q == len_q) || (hit_q && is_pkt));

	// read address: the queried entry or the scan pointer
	assign rd_en  = issue;
	assign rd_idx = (item_q.req_type == REQ_QUERY) ? IW'(item_q.peer_query) : iss_q[IW-1:0];

	// stale test on the returned entry
	assign ls_zero = (rd_ls == '0);
	assign expiry  = rd_ls + TICK_W'(cfg.timeout_ticks);
	assign stale   = !ls_zero && (expiry < item_q.tick);

	// effective table limit
	assign lim = (cfg.max_peers == '0 || 32'(cfg.max_peers) > NUM_PEERS)
		? CW'(NUM_PEERS) : CW'(cfg.max_peers);

	// next state, decision and write-back
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		res_push = 1'b0;
		res      = '0;
		wr       = '0;
		wr_idx   = hidx_q;
		used_d   = used_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stop) state_d = S_FINAL;
			end
			S_FINAL: begin
				res.status = ST_INVALID;
				case (item_q.req_type)
					REQ_PACKET: begin
						if (hit_q) begin
							wr.ls_en       = 1'b1;
							wr.ls          = item_q.tick;
							res.status     = item_q.is_hello ? ST_HELLO : ST_DELIVERED;
							res.peer_index = PIDX_W'(hidx_q);
						end else if (!cfg.client_mode && !item_q.is_hello) begin
							res.status = ST_NOT_CLIENT;
						end else if (!free_q && used_q >= lim) begin
							res.status = ST_FULL;
						end else begin
							wr_idx         = free_q ? fidx_q : IW'(used_q);
							wr.ls_en       = 1'b1;
							wr.addr_en     = 1'b1;
							wr.ls          = item_q.tick;
							wr.addr        = item_q.src_addr;
							res.status     = item_q.is_hello ? ST_HELLO : ST_DELIVERED;
							res.peer_index = PIDX_W'(wr_idx);
							res.new_peer   = 1'b1;
							res.send_reply = !cfg.client_mode;
							if (!free_q) used_d = used_q + CW'(1);
						end
					end
					REQ_POLL: begin
						used_d = top_q;
						if (hit_q) begin
							wr.ls_en       = 1'b1;
							res.status     = ST_EXPIRED;
							res.peer_index = PIDX_W'(hidx_q);
						end else begin
							res.status = ST_NONE_EXPIRED;
						end
					end
					REQ_QUERY: begin
						res.status     = hit_q ? ST_VALID : ST_INVALID;
						res.peer_index = item_q.peer_query;
					end
					default: res.status = ST_INVALID;
				endcase
				res.peer_count = COUNT_W'(used_d);
				if (res_free) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end else begin
					wr     = '0;
					used_d = used_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and table fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			v_s1    <= issue;
		end
	end

	// scan pointer and per-item flags
	always_ff @(posedge clk) begin
		if (issue) begin
			iss_q  <= iss_q + CW'(1);
			idx_s1 <= rd_idx;
		end
		if (accept) begin
			item_q <= item;
			iss_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			top_q  <= '0;
			case (item.req_type)
				REQ_PACKET, REQ_POLL: len_q <= used_q;
				REQ_QUERY: len_q <= (32'(item.peer_query) < 32'(used_q)) ? CW'(1) : '0;
				default: len_q <= '0;
			endcase
		end else if (v_s1) begin
			case (item_q.req_type)
				REQ_PACKET: begin
					if (!hit_q && rd_addr == item_q.src_addr) begin
						hit_q  <= 1'b1;
						hidx_q <= idx_s1;
					end
					if (!free_q && ls_zero) begin
						free_q <= 1'b1;
						fidx_q <= idx_s1;
					end
				end
				REQ_POLL: begin
					if (!hit_q && stale) begin
						hit_q  <= 1'b1;
						hidx_q <= idx_s1;
					end else if (!ls_zero) begin
						top_q <= CW'(idx_s1) + CW'(1);
					end
				end
				REQ_QUERY: hit_q <= !ls_zero;
				default: hit_q <= 1'b0;
			endcase
		end
	end

endmodule

FILE: hw/rtl/peer_table_learn_and_age.sv
// ----------------------------------------------------------------------------
// peer_table_learn_and_age: peer table with address learning and aging
// Top level: register file, table store, sequencer and output register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: a packet arrival (learn or refresh the
//   sender), a poll (expire the first stale peer and trim the table top) or a
//   query (is one entry valid). rsp returns exactly one result per request.
//   cfg writes client_mode, max_peers and timeout_ticks by index; write it
//   only while no request is in flight.
// Scan and flow:
//   A packet or poll scans the used entries, one memory read per cycle on
//   the single read port; a packet that matches stops its scan early. A
//   query reads at most one entry. The registered read and the write-back
//   follow the scan.
//   One request is worked at a time; req is ready again after write-back.
// Reset:
//   The table comes up empty: per-entry valid bits make every last-seen
//   entry read as free, so no clearing pass is run. Registers take their
//   defaults (host mode, 16 peers, 1000 ticks).
// Stall:
//   A result waits in the output register while the next request is taken;
//   the sequencer holds its write-back until that register is free.
// ----------------------------------------------------------------------------
module peer_table_learn_and_age import ptla_pkg::*; #(
	parameter int NUM_PEERS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	ptla_req_if.sink   req,
	ptla_rsp_if.source rsp,
	ptla_cfg_if.sink   cfg
);
	localparam int IW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

	cfg_t      cfg_q;
	req_item_t item;
	res_t      res, res_q;
	logic      out_valid_q, res_free, res_push;
	logic      rd_en;
	logic [IW-1:0]     rd_idx, wr_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [TICK_W-1:0] rd_ls;
	mem_wr_t   wr;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.client_mode   <= 1'b0;
			cfg_q.max_peers     <= MAX_PEERS_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CLIENT_MODE: cfg_q.client_mode   <= cfg.data[0];
				CFG_MAX_PEERS:   cfg_q.max_peers     <= cfg.data[MAXP_W-1:0];
				CFG_TIMEOUT:     cfg_q.timeout_ticks <= cfg.data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	assign item.req_type   = req.req_type;
	assign item.src_addr   = req.src_addr;
	assign item.is_hello   = req.is_hello;
	assign item.tick       = req.tick;
	assign item.peer_query = req.peer_query;

	ptla_seq #(.NUM_PEERS(NUM_PEERS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.item     (item),
		.res_free (res_free),
		.res_push (res_push),
		.res      (res),
		.rd_en    (rd_en),
		.rd_idx   (rd_idx),
		.rd_addr  (rd_addr),
		.rd_ls    (rd_ls),
		.wr_idx   (wr_idx),
		.wr       (wr)
	);

	ptla_store #(.NUM_PEERS(NUM_PEERS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_addr (rd_addr),
		.rd_ls   (rd_ls),
		.wr_idx  (wr_idx),
		.wr      (wr)
	);

	// output register: load a result, drop it once taken
	assign res_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_q <= res;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = res_q.status;
	assign rsp.peer_index = res_q.peer_index;
	assign rsp.new_peer   = res_q.new_peer;
	assign rsp.send_reply = res_q.send_reply;
	assign rsp.peer_count = res_q.peer_count;

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	// only a delivered or absorbed packet can take a slot
	a_new_peer_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.new_peer |-> rsp.status == ST_DELIVERED || rsp.status == ST_HELLO)
		else $error("new peer flagged with a refusing status");

	// a reply goes only to a newly learned peer in host mode
	a_reply_host: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.send_reply |-> res.new_peer && !cfg_q.client_mode)
		else $error("hello reply outside host learning");

	// no table write without a result leaving the sequencer
	a_write_push: assert property (@(posedge clk) disable iff (!arst_n)
		wr.ls_en |-> res_push)
		else $error("table written without a result");

endmodule

FILE: tb/tb_peer_table_learn_and_age.sv
// ----------------------------------------------------------------------------
// tb_peer_table_learn_and_age: self-checking bench for the peer table
// Drives packet, poll, query and unused requests through the request channel,
// predicts every result from a local copy of the table, and compares each
// result beat field by field. Covers host and client modes, table limits,
// aging with counter wrap, and four sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_peer_table_learn_and_age;
	import ptla_pkg::*;

	localparam int NUM_PEERS     = 16;
	localparam int SETTLE_CYCLES = NUM_PEERS + 8;
	localparam int POOL_SIZE     = 20;
	localparam logic [1:0]        REQ_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;

	bit   clk;
	logic arst_n;

	ptla_req_if req_ch ();
	ptla_rsp_if rsp_ch ();
	ptla_cfg_if cfg_ch ();

	peer_table_learn_and_age #(.NUM_PEERS(NUM_PEERS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the peer table and its registers
	logic [ADDR_W-1:0]    tbl_addr [NUM_PEERS];
	logic [TICK_W-1:0]    tbl_seen [NUM_PEERS];
	int                   tbl_used;
	logic                 m_client;
	logic [MAXP_W-1:0]    m_max_peers;
	logic [TIMEOUT_W-1:0] m_timeout;

	res_t expected_results[$];

	int fail_count;
	int sent_count;
	int checked_count;
	int cfg_count;
	int expire_count;
	int full_count;
	int send_idle_pct;
	int stall_pct;

	logic [TICK_W-1:0] now_tick;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	// Clock: period of 2
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Safety limit on run length
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("MISMATCH: %s", msg);
		end
	endfunction

	function automatic void reset_peer_table();
		for (int i = 0; i < NUM_PEERS; i++) begin
			tbl_addr[i] = '0;
			tbl_seen[i] = '0;
		end
		tbl_used    = 0;
		m_client    = 1'b0;
		m_max_peers = MAX_PEERS_RST;
		m_timeout   = TIMEOUT_RST;
	endfunction

	// Compute the result of one request and advance the shadow table
	function automatic res_t predict_table_step(req_item_t it);
		res_t              r;
		int                n;
		int                i;
		int                lim_n;
		logic [TICK_W-1:0] lim;
		r = '0;
		n = tbl_used;
		case (it.req_type)
			REQ_PACKET: begin
				i = 0;
				while (i < n && tbl_addr[i] != it.src_addr) i++;
				if (i == n) begin
					// stranger: refuse in host mode unless it says hello
					if (!m_client && !it.is_hello) begin
						r.status     = ST_NOT_CLIENT;
						r.peer_count = COUNT_W'(tbl_used);
						return r;
					end
					i = 0;
					while (i < n && tbl_seen[i] != '0) i++;
					if (i == n) begin
						lim_n = (m_max_peers == 0 || m_max_peers > NUM_PEERS) ?
							NUM_PEERS : int'(m_max_peers);
						if (n >= lim_n) begin
							r.status     = ST_FULL;
							r.peer_count = COUNT_W'(tbl_used);
							return r;
						end
						tbl_used = n + 1;
					end
					tbl_addr[i]  = it.src_addr;
					r.new_peer   = 1'b1;
					r.send_reply = !m_client;
				end
				tbl_seen[i]  = it.tick;
				r.status     = it.is_hello ? ST_HELLO : ST_DELIVERED;
				r.peer_index = PIDX_W'(i);
			end
			REQ_POLL: begin
				r.status = ST_NONE_EXPIRED;
				for (i = 0; i < n; i++) begin
					lim = tbl_seen[i] + TICK_W'(m_timeout);
					if (tbl_seen[i] != '0 && lim < it.tick) begin
						tbl_seen[i]  = '0;
						r.status     = ST_EXPIRED;
						r.peer_index = PIDX_W'(i);
						break;
					end
				end
				// trim free entries off the top
				while (n > 0 && tbl_seen[n-1] == '0) n--;
				tbl_used = n;
			end
			REQ_QUERY: begin
				r.peer_index = it.peer_query;
				if (int'(it.peer_query) < n && tbl_seen[it.peer_query] != '0) begin
					r.status = ST_VALID;
				end else begin
					r.status = ST_INVALID;
				end
			end
			default: begin
				r.status = ST_INVALID;
			end
		endcase
		r.peer_count = COUNT_W'(tbl_used);
		return r;
	endfunction

	function automatic req_item_t mk_req(logic [1:0] kind, logic [ADDR_W-1:0] addr,
		logic hello, logic [TICK_W-1:0] tick, logic [QUERY_W-1:0] query);
		req_item_t it;
		it.req_type   = kind;
		it.src_addr   = addr;
		it.is_hello   = hello;
		it.tick       = tick;
		it.peer_query = query;
		return it;
	endfunction

	// Mostly well-formed traffic: known peers, advancing time, some noise
	function automatic req_item_t random_request();
		req_item_t it;
		int        roll;
		int        t;
		roll = $urandom_range(99);
		if (roll < 55) it.req_type = REQ_PACKET;
		else if (roll < 80) it.req_type = REQ_POLL;
		else if (roll < 95) it.req_type = REQ_QUERY;
		else it.req_type = REQ_UNUSED;
		if ($urandom_range(9) == 0) begin
			it.src_addr = ADDR_W'({$urandom(), $urandom()});
		end else begin
			it.src_addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
		end
		it.is_hello   = 1'($urandom_range(1));
		it.peer_query = QUERY_W'($urandom_range(15));
		t = $urandom_range(99);
		if (t < 4) begin
			it.tick = $urandom();
		end else if (t < 6) begin
			it.tick = '0;
		end else begin
			if (t < 16) begin
				now_tick = now_tick + TICK_W'(m_timeout) + TICK_W'($urandom_range(2));
			end else begin
				now_tick = now_tick + TICK_W'($urandom_range(int'(m_timeout) / 8 + 2));
			end
			it.tick = now_tick;
		end
		return it;
	endfunction

	// Send one request beat and record its expected result
	task automatic send_item(req_item_t it);
		res_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= it.req_type;
		req_ch.src_addr   <= it.src_addr;
		req_ch.is_hello   <= it.is_hello;
		req_ch.tick       <= it.tick;
		req_ch.peer_query <= it.peer_query;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		r = predict_table_step(it);
		expected_results.push_back(r);
		sent_count++;
		if (r.status == ST_EXPIRED) expire_count++;
		if (r.status == ST_FULL) full_count++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_CLIENT_MODE: m_client    = value[0];
			CFG_MAX_PEERS:   m_max_peers = value[MAXP_W-1:0];
			CFG_TIMEOUT:     m_timeout   = value;
			default: ;
		endcase
		cfg_count++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold requests until every result is back and the block has settled
	task automatic wait_table_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result receiver: random stalls
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : rsp_check
		res_t got;
		res_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.status     = rsp_ch.status;
			got.peer_index = rsp_ch.peer_index;
			got.new_peer   = rsp_ch.new_peer;
			got.send_reply = rsp_ch.send_reply;
			got.peer_count = rsp_ch.peer_count;
			if (expected_results.size() == 0) begin
				note_failure($sformatf("result with nothing pending: status %0d index %0d",
					got.status, got.peer_index));
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (got.status !== want.status || got.peer_index !== want.peer_index ||
					got.new_peer !== want.new_peer || got.send_reply !== want.send_reply ||
					got.peer_count !== want.peer_count) begin
					note_failure($sformatf({"result %0d: expected st %0d idx %0d new %0b ",
						"rep %0b cnt %0d, got st %0d idx %0d new %0b rep %0b cnt %0d"},
						checked_count, want.status, want.peer_index, want.new_peer,
						want.send_reply, want.peer_count, got.status, got.peer_index,
						got.new_peer, got.send_reply, got.peer_count));
				end
			end
		end
	end

	// Host mode at reset defaults: refusal, hello learning, zero tick, expiry
	task automatic test_host_learning();
		send_item(mk_req(REQ_QUERY, '0, 1'b0, 32'd1, 4'd15));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'd5, 4'd0));
		send_item(mk_req(REQ_PACKET, ADDR_ONES, 1'b0, 32'd10, 4'd0));
		send_item(mk_req(REQ_PACKET, ADDR_ONES, 1'b1, '1, 4'd0));
		send_item(mk_req(REQ_PACKET, ADDR_ONES, 1'b0, 32'd20, 4'd0));
		// seen at tick zero: the slot stays free
		send_item(mk_req(REQ_PACKET, '0, 1'b1, 32'd0, 4'd0));
		send_item(mk_req(REQ_QUERY, '0, 1'b0, 32'd25, 4'd1));
		send_item(mk_req(REQ_QUERY, '0, 1'b0, 32'd25, 4'd0));
		send_item(mk_req(REQ_PACKET, 48'h1234_5678_9ABC, 1'b1, 32'd30, 4'd0));
		send_item(mk_req(REQ_UNUSED, 48'hA5A5_A5A5_A5A5, 1'b1, 32'h5A5A_5A5A, 4'd9));
		send_item(mk_req(REQ_POLL, '0, 1'b0, '1, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, '1, 4'd0));
	endtask

	// Client mode, one-entry table, longest timeout and tick wrap
	task automatic test_client_and_full();
		wait_table_idle();
		write_reg(CFG_CLIENT_MODE, 16'd1);
		write_reg(CFG_MAX_PEERS, 16'd1);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		send_item(mk_req(REQ_PACKET, 48'h0A00_0001_1F90, 1'b0, 32'd100, 4'd0));
		send_item(mk_req(REQ_PACKET, 48'hC0A8_0102_2710, 1'b0, 32'd150, 4'd0));
		send_item(mk_req(REQ_PACKET, 48'h0A00_0001_1F90, 1'b1, 32'd200, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'd65735, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'd65736, 4'd0));
		send_item(mk_req(REQ_PACKET, 48'h0A00_0001_1F90, 1'b0, 32'hFFFF_FFF0, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'h0001_0000, 4'd0));
	endtask

	// Timeout of one tick, max_peers of zero allows all NUM_PEERS entries
	task automatic test_fast_aging();
		wait_table_idle();
		write_reg(CFG_CLIENT_MODE, 16'd0);
		write_reg(CFG_MAX_PEERS, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd1);
		send_item(mk_req(REQ_PACKET, 48'h7F00_0001_0050, 1'b1, 32'd50, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'd51, 4'd0));
		send_item(mk_req(REQ_POLL, '0, 1'b0, 32'd52, 4'd0));
		send_item(mk_req(REQ_QUERY, '0, 1'b0, 32'd53, 4'd15));
	endtask

	// Random traffic over eight register settings and four idle patterns
	task automatic test_random_traffic();
		int                   ph;
		int                   k;
		logic [CFG_DAT_W-1:0] maxp;
		logic [CFG_DAT_W-1:0] tmo;
		for (ph = 0; ph < 8; ph++) begin
			wait_table_idle();
			case (ph)
				0: begin maxp = 16'd16; tmo = 16'd1000; end
				1: begin maxp = 16'd1;  tmo = 16'd1;    end
				2: begin maxp = 16'd3;  tmo = 16'hFFFF; end
				3: begin maxp = 16'd0;  tmo = 16'd40;   end
				4: begin maxp = 16'd16; tmo = 16'd300;  end
				5: begin maxp = 16'd31; tmo = 16'hFFFF; end
				6: begin maxp = 16'd2;  tmo = 16'd5;    end
				default: begin
					maxp = CFG_DAT_W'($urandom_range(1, 16));
					tmo  = CFG_DAT_W'($urandom_range(1, 65535));
				end
			endcase
			write_reg(CFG_CLIENT_MODE, CFG_DAT_W'(ph % 2));
			write_reg(CFG_MAX_PEERS, maxp);
			write_reg(CFG_TIMEOUT, tmo);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 86; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 86; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			for (k = 0; k < POOL_SIZE; k++) begin
				addr_pool[k] = ADDR_W'({$urandom(), $urandom()});
			end
			// phase 5 starts just short of the tick wrap
			now_tick = (ph == 5) ? 32'hFFFF_FF00 : TICK_W'($urandom_range(1, 1000));
			for (k = 0; k < 100; k++) begin
				if (ph == 1 && k == 50) wait_table_idle();
				send_item(random_request());
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PACKET;
		req_ch.src_addr   = '0;
		req_ch.is_hello   = 1'b0;
		req_ch.tick       = '0;
		req_ch.peer_query = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_CLIENT_MODE;
		cfg_ch.data       = '0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		now_tick          = '0;
		reset_peer_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_host_learning();
		test_client_and_full();
		test_fast_aging();
		test_random_traffic();

		wait_table_idle();
		if (expected_results.size() != 0) begin
			fail_count += expected_results.size();
			$display("%0d results never arrived", expected_results.size());
		end
		$display("Ran %0d requests, checked %0d results, %0d register writes",
			sent_count, checked_count, cfg_count);
		$display("Saw %0d expiries and %0d full-table drops across host and client modes",
			expire_count, full_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ptla_pkg.sv
hw/rtl/ptla_if.sv
hw/rtl/ptla_store.sv
hw/rtl/ptla_seq.sv
hw/rtl/peer_table_learn_and_age.sv
tb/tb_peer_table_learn_and_age.sv
